@@ hw/rtl/wfnc_pkg.sv @@
// wfnc_pkg: shared types and constants for the wall follow navigation controller
// mode codes, controller states, command struct, register indexes, divider constants
// no dependencies
package wfnc_pkg;

    // default widths
    localparam int SENSOR_BITS_DEF = 10;
    localparam int SPEED_BITS_DEF  = 15;

    // fixed field widths
    localparam int HEADING_W = 12;
    localparam int MODE_W    = 3;
    localparam int LOCK_W    = 6;
    localparam int MAXSPD_W  = 15;
    localparam int REG_IDX_W = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SPEED     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AVOID_LOCK     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TURN_LOCK      = 2'd3;

    // register reset values
    localparam int unsigned DISTANCE_LIMIT_RST = 100;
    localparam logic [MAXSPD_W-1:0] FULL_SPEED_RST = 15'd6280;
    localparam logic [LOCK_W-1:0]   AVOID_LOCK_RST = 6'd30;
    localparam logic [LOCK_W-1:0]   TURN_LOCK_RST  = 6'd50;

    // heading thresholds in tenths of a degree
    localparam logic [HEADING_W-1:0] HEADING_SNAP_HI  = 12'd3570;
    localparam logic [HEADING_W-1:0] HEADING_SNAP_LO  = 12'd30;
    localparam logic [HEADING_W-1:0] ORIENT_BAND_LO   = 12'd1750;
    localparam logic [HEADING_W-1:0] ORIENT_BAND_HI   = 12'd1850;
    localparam logic [HEADING_W-1:0] HEADING_SOUTH    = 12'd1800;
    localparam logic [HEADING_W-1:0] ORIENT_LEFT_MAX  = 12'd1780;
    localparam logic [HEADING_W-1:0] ORIENT_RIGHT_MIN = 12'd1820;
    localparam int ERR_W = 9;
    localparam logic [ERR_W-1:0]     ERR_CAP          = 9'd450;

    // every speed magnitude is floor(full_speed * k / DIV_BASE)
    localparam int K_W = 13;
    localparam logic [K_W-1:0] K_HALF   = 13'd4500;
    localparam logic [K_W-1:0] K_SIXTH  = 13'd1500;
    localparam logic [K_W-1:0] K_NINTH  = 13'd1000;
    localparam logic [K_W-1:0] K_3_10   = 13'd2700;
    localparam logic [K_W-1:0] K_3_20   = 13'd1350;

    // reciprocal divide: exact for numerators below 2**28
    localparam longint unsigned DIV_BASE = 64'd9000;
    localparam int DIV_SHIFT = 42;
    localparam int RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + DIV_BASE - 64'd1) / DIV_BASE);
    localparam int N_W = MAXSPD_W + K_W;
    localparam int P_W = N_W + RECIP_W;
    localparam int Q_W = P_W - DIV_SHIFT;

    typedef enum logic [MODE_W-1:0] {
        MODE_FORWARD = 3'd0,
        MODE_WALL    = 3'd1,
        MODE_ORIENT  = 3'd2,
        MODE_AVOID   = 3'd3,
        MODE_TLEFT   = 3'd4,
        MODE_TRIGHT  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCALE,
        ST_RECIP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic scale;
        logic recip;
        logic commit;
    } cmd_t;

endpackage

@@ hw/rtl/wfnc_tick_if.sv @@
// wfnc_tick_if: input channel carrying one control tick of sensor readings
// depends on wfnc_pkg
interface wfnc_tick_if #(parameter int SENSOR_BITS = wfnc_pkg::SENSOR_BITS_DEF);
    logic                             valid;
    logic                             ready;
    logic [SENSOR_BITS-1:0]           front_a;
    logic [SENSOR_BITS-1:0]           front_b;
    logic [SENSOR_BITS-1:0]           rear_right;
    logic [SENSOR_BITS-1:0]           fore_right;
    logic [SENSOR_BITS-1:0]           rear_left;
    logic [SENSOR_BITS-1:0]           fore_left;
    logic [wfnc_pkg::HEADING_W-1:0]   heading_tenths;

    modport source (
        output valid, front_a, front_b, rear_right, fore_right, rear_left, fore_left,
        output heading_tenths,
        input  ready
    );
    modport sink (
        input  valid, front_a, front_b, rear_right, fore_right, rear_left, fore_left,
        input  heading_tenths,
        output ready
    );
endinterface

@@ hw/rtl/wfnc_drive_if.sv @@
// wfnc_drive_if: output channel carrying mode, wheel speeds and lock count
// depends on wfnc_pkg
interface wfnc_drive_if #(parameter int SPEED_BITS = wfnc_pkg::SPEED_BITS_DEF);
    logic                           valid;
    logic                           ready;
    logic [wfnc_pkg::MODE_W-1:0]    mode;
    logic signed [SPEED_BITS-1:0]   left_speed;
    logic signed [SPEED_BITS-1:0]   right_speed;
    logic [wfnc_pkg::LOCK_W-1:0]    lock_remaining;

    modport source (
        output valid, mode, left_speed, right_speed, lock_remaining,
        input  ready
    );
    modport sink (
        input  valid, mode, left_speed, right_speed, lock_remaining,
        output ready
    );
endinterface

@@ hw/rtl/wfnc_ctrl.sv @@
// wfnc_ctrl: sequencing state machine and output valid register
// depends on wfnc_pkg
module wfnc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output wfnc_pkg::cmd_t cmd
);
    import wfnc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (out_free)
                    state_next = in_valid ? ST_DECIDE : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_RECIP:  cmd.recip  = 1'b1;
            ST_COMMIT:
            begin
                in_ready    = out_free;
                cmd.commit  = out_free;
                cmd.capture = out_free && in_valid;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/wfnc_dp.sv @@
// wfnc_dp: config registers, mode decision, speed scaling by reciprocal multiply
// depends on wfnc_pkg; driven by the command struct from wfnc_ctrl
module wfnc_dp #(
    parameter int SENSOR_BITS = wfnc_pkg::SENSOR_BITS_DEF,
    parameter int SPEED_BITS  = wfnc_pkg::SPEED_BITS_DEF,
    parameter int CFG_W       = wfnc_pkg::MAXSPD_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wfnc_pkg::cmd_t                     cmd,
    input  logic                               cfg_we,
    input  logic [wfnc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    input  logic [SENSOR_BITS-1:0]             front_a,
    input  logic [SENSOR_BITS-1:0]             front_b,
    input  logic [SENSOR_BITS-1:0]             rear_right,
    input  logic [SENSOR_BITS-1:0]             fore_right,
    input  logic [SENSOR_BITS-1:0]             rear_left,
    input  logic [SENSOR_BITS-1:0]             fore_left,
    input  logic [wfnc_pkg::HEADING_W-1:0]     heading_tenths,
    output logic [wfnc_pkg::MODE_W-1:0]        mode,
    output logic signed [SPEED_BITS-1:0]       left_speed,
    output logic signed [SPEED_BITS-1:0]       right_speed,
    output logic [wfnc_pkg::LOCK_W-1:0]        lock_remaining
);
    import wfnc_pkg::*;

    localparam int SAT_W = ((SPEED_BITS > Q_W) ? SPEED_BITS : Q_W) + 2;
    localparam logic signed [SAT_W-1:0] SPD_HI =
        SAT_W'((longint'(1) << (SPEED_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SPD_LO = SAT_W'(-SPD_HI - SAT_W'(1));

    // config
    logic [SENSOR_BITS-1:0] dist_limit_reg;
    logic [MAXSPD_W-1:0]    full_speed_reg;
    logic [LOCK_W-1:0]      avoid_lock_reg;
    logic [LOCK_W-1:0]      turn_lock_reg;

    // captured tick
    logic [SENSOR_BITS-1:0] fa_reg, fb_reg, br_reg, fr_reg, bl_reg, fl_reg;
    logic [HEADING_W-1:0]   head_reg;

    // controller state
    mode_t                  mode_reg, mode_next;
    logic [LOCK_W-1:0]      lock_reg, lock_next;
    logic                   btl_reg, btl_next;
    logic signed [SPEED_BITS-1:0] held_l_reg, held_l_next;
    logic signed [SPEED_BITS-1:0] held_r_reg, held_r_next;

    // per-wheel plan and divider lanes
    logic                   upd_l_reg, upd_l_next, upd_r_reg, upd_r_next;
    logic                   neg_l_reg, neg_l_next, neg_r_reg, neg_r_next;
    logic [K_W-1:0]         k_l_reg, k_l_next, k_r_reg, k_r_next;
    logic [N_W-1:0]         n_l_reg, n_l_next, n_r_reg, n_r_next;
    logic [Q_W-1:0]         q_l_reg, q_l_next, q_r_reg, q_r_next;
    logic [P_W-1:0]         prod_l, prod_r;

    // output payload
    mode_t                        out_mode_reg;
    logic [LOCK_W-1:0]            out_lock_reg;
    logic signed [SPEED_BITS-1:0] out_l_reg, out_r_reg;

    // decision terms
    logic [SENSOR_BITS:0]   fsum, lim2;
    logic [HEADING_W-1:0]   h_snap, h_diff;
    logic [ERR_W-1:0]       err;
    logic [K_W-1:0]         k_fwd, k_bwd;
    logic br_gt, fr_gt, bl_gt, fl_gt, fa_gt, fb_gt;
    logic locked, orient_cond, avoid_req, corner, wall_c1, wall_c2;

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(
        input logic neg, input logic [Q_W-1:0] q);
        logic signed [SAT_W-1:0] v;
        logic signed [SAT_W-1:0] c;
        v = $signed(SAT_W'(q));
        if (neg)
            v = -v;
        if (v > SPD_HI)
            c = SPD_HI;
        else if (v < SPD_LO)
            c = SPD_LO;
        else
            c = v;
        return c[SPEED_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg <= SENSOR_BITS'(DISTANCE_LIMIT_RST);
            full_speed_reg <= FULL_SPEED_RST;
            avoid_lock_reg <= AVOID_LOCK_RST;
            turn_lock_reg  <= TURN_LOCK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISTANCE_LIMIT: dist_limit_reg <= cfg_data[SENSOR_BITS-1:0];
                REG_FULL_SPEED:     full_speed_reg <= cfg_data[MAXSPD_W-1:0];
                REG_AVOID_LOCK:     avoid_lock_reg <= cfg_data[LOCK_W-1:0];
                REG_TURN_LOCK:      turn_lock_reg  <= cfg_data[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fa_reg   <= front_a;
            fb_reg   <= front_b;
            br_reg   <= rear_right;
            fr_reg   <= fore_right;
            bl_reg   <= rear_left;
            fl_reg   <= fore_left;
            head_reg <= heading_tenths;
        end
    end

    // sensor and heading terms
    always_comb
    begin
        fsum   = {1'b0, fa_reg} + {1'b0, fb_reg};
        lim2   = {dist_limit_reg, 1'b0};
        br_gt  = br_reg > dist_limit_reg;
        fr_gt  = fr_reg > dist_limit_reg;
        bl_gt  = bl_reg > dist_limit_reg;
        fl_gt  = fl_reg > dist_limit_reg;
        fa_gt  = fa_reg > dist_limit_reg;
        fb_gt  = fb_reg > dist_limit_reg;
        // near north counts as zero, and so does anything past the wrap
        if (head_reg > HEADING_SNAP_HI || head_reg < HEADING_SNAP_LO)
            h_snap = '0;
        else
            h_snap = head_reg;
        if (h_snap >= HEADING_SOUTH)
            h_diff = h_snap - HEADING_SOUTH;
        else
            h_diff = HEADING_SOUTH - h_snap;
        err    = (h_diff > HEADING_W'(ERR_CAP)) ? ERR_CAP : h_diff[ERR_W-1:0];
        k_bwd  = K_W'({err, 2'b00});
        k_fwd  = K_W'({err, 2'b00}) + K_W'(err);
        locked = (mode_reg == MODE_AVOID && fsum != '0) || lock_reg != '0;
        orient_cond = fr_reg == '0 && br_reg == '0 && fa_reg == '0 && fb_reg == '0
                   && (h_snap < ORIENT_BAND_LO || h_snap > ORIENT_BAND_HI);
        avoid_req = mode_reg != MODE_AVOID && (fa_gt || fb_gt);
        corner    = fr_gt && fsum > lim2;
        wall_c1   = (br_gt && br_reg > fr_reg) || (fl_gt && bl_reg < fl_reg);
        wall_c2   = (fr_gt && br_reg < fr_reg) || (bl_gt && bl_reg > fl_reg);
    end

    // mode decision; when unlocked, later rules override earlier ones for the mode, but the first lock loaded stays
    always_comb
    begin
        mode_next = mode_reg;
        lock_next = lock_reg;
        btl_next  = btl_reg;
        if (locked)
        begin
            if (lock_reg != '0)
                lock_next = lock_reg - LOCK_W'(1);
        end
        else
        begin
            mode_next = MODE_FORWARD;
            if (br_gt || fr_gt || bl_gt || fl_gt)
                mode_next = MODE_WALL;
            if (orient_cond)
                mode_next = MODE_ORIENT;
            if (avoid_req)
            begin
                mode_next = MODE_AVOID;
                btl_next  = !btl_reg;
                if (lock_next == '0)
                    lock_next = avoid_lock_reg;
            end
            if (corner && br_gt)
            begin
                mode_next = MODE_TLEFT;
                if (lock_next == '0)
                    lock_next = turn_lock_reg;
            end
            if (corner && bl_gt)
            begin
                mode_next = MODE_TRIGHT;
                if (lock_next == '0)
                    lock_next = turn_lock_reg;
            end
        end
    end

    // speed plan for the new mode; no update means the wheel holds
    always_comb
    begin
        upd_l_next = 1'b0;
        upd_r_next = 1'b0;
        neg_l_next = 1'b0;
        neg_r_next = 1'b0;
        k_l_next   = '0;
        k_r_next   = '0;
        case (mode_next)
            MODE_FORWARD:
            begin
                upd_l_next = 1'b1;
                upd_r_next = 1'b1;
                k_l_next   = K_HALF;
                k_r_next   = K_HALF;
            end
            MODE_AVOID:
            begin
                upd_l_next = 1'b1;
                upd_r_next = 1'b1;
                neg_l_next = btl_next;
                neg_r_next = !btl_next;
                k_l_next   = btl_next ? K_SIXTH : K_NINTH;
                k_r_next   = btl_next ? K_NINTH : K_SIXTH;
            end
            MODE_WALL:
            begin
                if (wall_c1 || wall_c2)
                begin
                    upd_l_next = 1'b1;
                    upd_r_next = 1'b1;
                end
                if (wall_c2)
                begin
                    k_l_next = K_3_20;
                    k_r_next = K_3_10;
                end
                else
                begin
                    k_l_next = K_3_10;
                    k_r_next = K_3_20;
                end
            end
            MODE_TLEFT:
            begin
                upd_l_next = 1'b1;
                upd_r_next = 1'b1;
                neg_l_next = 1'b1;
                k_l_next   = K_SIXTH;
                k_r_next   = K_NINTH;
            end
            MODE_TRIGHT:
            begin
                upd_l_next = 1'b1;
                upd_r_next = 1'b1;
                neg_r_next = 1'b1;
                k_l_next   = K_NINTH;
                k_r_next   = K_SIXTH;
            end
            MODE_ORIENT:
            begin
                if (h_snap <= ORIENT_LEFT_MAX)
                begin
                    upd_l_next = 1'b1;
                    upd_r_next = 1'b1;
                    neg_l_next = 1'b1;
                    k_l_next   = k_bwd;
                    k_r_next   = k_fwd;
                end
                if (h_snap >= ORIENT_RIGHT_MIN)
                begin
                    upd_l_next = 1'b1;
                    upd_r_next = 1'b1;
                    neg_r_next = 1'b1;
                    k_l_next   = k_fwd;
                    k_r_next   = k_bwd;
                end
            end
            default: ;
        endcase
    end

    // numerator, then multiply by the reciprocal of the common divisor
    always_comb
    begin
        n_l_next = N_W'(full_speed_reg) * N_W'(k_l_reg);
        n_r_next = N_W'(full_speed_reg) * N_W'(k_r_reg);
        prod_l   = P_W'(n_l_reg) * P_W'(DIV_RECIP);
        prod_r   = P_W'(n_r_reg) * P_W'(DIV_RECIP);
        q_l_next = prod_l[DIV_SHIFT +: Q_W];
        q_r_next = prod_r[DIV_SHIFT +: Q_W];
        held_l_next = upd_l_reg ? sat_speed(neg_l_reg, q_l_reg) : held_l_reg;
        held_r_next = upd_r_reg ? sat_speed(neg_r_reg, q_r_reg) : held_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FORWARD;
            lock_reg   <= '0;
            btl_reg    <= 1'b1;
            held_l_reg <= '0;
            held_r_reg <= '0;
        end
        else
        begin
            if (cmd.decide)
            begin
                mode_reg <= mode_next;
                lock_reg <= lock_next;
                btl_reg  <= btl_next;
            end
            if (cmd.commit)
            begin
                held_l_reg <= held_l_next;
                held_r_reg <= held_r_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            upd_l_reg <= upd_l_next;
            upd_r_reg <= upd_r_next;
            neg_l_reg <= neg_l_next;
            neg_r_reg <= neg_r_next;
            k_l_reg   <= k_l_next;
            k_r_reg   <= k_r_next;
        end
        if (cmd.scale)
        begin
            n_l_reg <= n_l_next;
            n_r_reg <= n_r_next;
        end
        if (cmd.recip)
        begin
            q_l_reg <= q_l_next;
            q_r_reg <= q_r_next;
        end
        if (cmd.commit)
        begin
            out_mode_reg <= mode_reg;
            out_lock_reg <= lock_reg;
            out_l_reg    <= held_l_next;
            out_r_reg    <= held_r_next;
        end
    end

    assign mode           = out_mode_reg;
    assign lock_remaining = out_lock_reg;
    assign left_speed     = out_l_reg;
    assign right_speed    = out_r_reg;

endmodule

@@ hw/rtl/wall_follow_navigation_controller.sv @@
// wall_follow_navigation_controller: each tick passes decide, scale, reciprocal and commit
// before its result is valid; one tick is in flight at a time, set by that sequence
// a new tick is taken in the commit cycle once the previous result is taken or none waits
// reset: async active low; registers back to defaults, mode forward, lock zero,
// backing turn left, held speeds zero, no result pending
module wall_follow_navigation_controller #(
    parameter int SENSOR_BITS = wfnc_pkg::SENSOR_BITS_DEF,
    parameter int SPEED_BITS  = wfnc_pkg::SPEED_BITS_DEF,
    localparam int CFG_W = (SENSOR_BITS > wfnc_pkg::MAXSPD_W) ? SENSOR_BITS
                                                               : wfnc_pkg::MAXSPD_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [wfnc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    // sensor tick in, drive command out
    wfnc_tick_if.sink                      tick_in,
    wfnc_drive_if.source                   drive_out
);
    import wfnc_pkg::*;

    // command bundle from the sequencer to the datapath
    cmd_t cmd;

    // sequencer: idle -> decide -> scale -> reciprocal -> commit
    // commit waits while a result is still held and not taken
    wfnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick_in.valid),
        .in_ready  (tick_in.ready),
        .out_valid (drive_out.valid),
        .out_ready (drive_out.ready),
        .cmd       (cmd)
    );

    // datapath: captures the tick, updates mode and lock, then scales both
    // wheel speeds as full_speed * k / 9000 with one reciprocal multiply per lane
    wfnc_dp #(
        .SENSOR_BITS (SENSOR_BITS),
        .SPEED_BITS  (SPEED_BITS),
        .CFG_W       (CFG_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .front_a        (tick_in.front_a),
        .front_b        (tick_in.front_b),
        .rear_right     (tick_in.rear_right),
        .fore_right     (tick_in.fore_right),
        .rear_left      (tick_in.rear_left),
        .fore_left      (tick_in.fore_left),
        .heading_tenths (tick_in.heading_tenths),
        .mode           (drive_out.mode),
        .left_speed     (drive_out.left_speed),
        .right_speed    (drive_out.right_speed),
        .lock_remaining (drive_out.lock_remaining)
    );

endmodule
